FILE: design/bcsr_acc_pkg.sv
// ----------------------------------------------------------------------------
// bcsr_acc_pkg
// Shared types, constants and arithmetic helpers of the BCSR SpMV accumulator.
// ----------------------------------------------------------------------------
`default_nettype none

package bcsr_acc_pkg;

    // Vector stores
    localparam int VEC_DEPTH = 4096;
    localparam int VEC_AW    = $clog2(VEC_DEPTH);

    // Field widths
    localparam int IDX_W  = 12;
    localparam int V_W    = 32;
    localparam int Y_W    = 48;
    localparam int PROD_W = 2 * V_W;
    localparam int FRAC_W = 16;
    localparam int ROW_W  = 13;
    localparam int MROW_W = 16;

    // Block shape
    localparam int MAX_DIM = 8;
    localparam int DIM_W   = 4;
    localparam int CNT_W   = $clog2(MAX_DIM);

    // Stream and configuration ports
    localparam int S_TDATA_W  = 72;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 13;

    // Queue between front and back, and result queue
    localparam int Q_DEPTH   = 4;
    localparam int Q_AW      = $clog2(Q_DEPTH);
    localparam int OUT_DEPTH = 8;
    localparam int OUT_AW    = $clog2(OUT_DEPTH);

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_ROWS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_COLS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ROW_START  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ROW_END    = 2'd3;

    localparam logic [ROW_W-1:0] ROW_END_RST = 13'd4096;

    typedef enum logic [1:0] {
        OP_LOAD_X = 2'd0,
        OP_LOAD_Y = 2'd1,
        OP_BLOCK  = 2'd2,
        OP_READ_Y = 2'd3
    } t_op;

    // Active configuration, block dimensions already clamped
    typedef struct packed {
        logic [DIM_W-1:0] rows;
        logic [DIM_W-1:0] cols;
        logic [ROW_W-1:0] row_start;
        logic [ROW_W-1:0] row_end;
    } t_cfg;

    // Classified command handed from front to back
    typedef struct packed {
        t_op                op;
        logic [VEC_AW-1:0]  x_addr;
        logic               x_ok;
        logic [VEC_AW-1:0]  y_addr;
        logic               y_en;
        logic               eor;
        logic [V_W-1:0]     value;
    } t_cmd;

    // Read result
    typedef struct packed {
        logic           sat;
        logic [Y_W-1:0] value;
    } t_res;

    // Map a block dimension of zero to one and cap it at the maximum
    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] d);
        if (d == '0) begin
            return DIM_W'(1);
        end else if (d > DIM_W'(MAX_DIM)) begin
            return DIM_W'(MAX_DIM);
        end
        return d;
    endfunction

    // Saturating Q32.16 add; bit Y_W of the result flags a clip
    function automatic logic [Y_W:0] sat_add(input logic [Y_W-1:0] a,
                                             input logic [Y_W-1:0] b);
        logic [Y_W:0] s;
        s = {a[Y_W-1], a} + {b[Y_W-1], b};
        if (s[Y_W] != s[Y_W-1]) begin
            if (s[Y_W]) begin
                return {1'b1, 1'b1, {(Y_W-1){1'b0}}};
            end
            return {1'b1, 1'b0, {(Y_W-1){1'b1}}};
        end
        return {1'b0, s[Y_W-1:0]};
    endfunction

endpackage

`default_nettype wire

FILE: design/bcsr_spmv_accumulator.sv
// ----------------------------------------------------------------------------
// bcsr_spmv_accumulator
// Block-compressed sparse matrix times vector accumulator, y += A*x, with
// Q16.16 inputs and a saturating Q32.16 y vector.
//
// Usage: the slave stream carries one command word per beat (tuser selects
// load x, load y, block element, read y). Block elements arrive row-major
// inside each block; the block shape and row window are set on the config
// channel while the block is idle. Only read y produces a master word.
// Throughput: one word per cycle, sustained, for every command type while
// read results do not back up; the x multiply and the y read-modify-write
// are pipelined, with the last y write forwarded so back-to-back row
// updates to one entry stay correct. A read y word passes the command
// queue, the back-end stages and the result queue before it reaches the
// master side. Reset clears the block counters, row sum, queues and
// configuration (1x1 blocks, full row window); x and y contents are kept
// and must be loaded before use. When the master side stalls, up to 8
// read results are held and the slave side keeps taking words until the
// 4-entry command queue fills behind a read that has no result slot.
// ----------------------------------------------------------------------------
`default_nettype none

module bcsr_spmv_accumulator (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    // tdata: index[11:0], element_value[43:12], block_row[55:44],
    //        col_start[67:56], zero[71:68]
    input  wire logic [bcsr_acc_pkg::S_TDATA_W-1:0]  s_axis_tdata,
    // tuser: operation[1:0]
    input  wire logic [1:0]                          s_axis_tuser,
    input  wire logic                                s_axis_tvalid,
    output logic                                     s_axis_tready,
    // tdata: read_value[47:0]
    output logic [bcsr_acc_pkg::Y_W-1:0]             m_axis_tdata,
    // tuser: saturated[0]
    output logic                                     m_axis_tuser,
    output logic                                     m_axis_tvalid,
    input  wire logic                                m_axis_tready,
    input  wire logic                                i_cfg_valid,
    output logic                                     o_cfg_ready,
    input  wire logic [bcsr_acc_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [bcsr_acc_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    logic [bcsr_acc_pkg::DIM_W-1:0] r_block_rows;
    logic [bcsr_acc_pkg::DIM_W-1:0] r_block_cols;
    logic [bcsr_acc_pkg::ROW_W-1:0] r_row_start;
    logic [bcsr_acc_pkg::ROW_W-1:0] r_row_end;
    logic                           w_cfg_we;
    logic                           w_shape_clr;
    bcsr_acc_pkg::t_cfg             w_cfg;

    logic                           w_accept;
    logic                           w_q_full;
    logic                           w_q_valid;
    logic                           w_q_pop;
    bcsr_acc_pkg::t_cmd             w_front_cmd;
    bcsr_acc_pkg::t_cmd             w_q_cmd;
    bcsr_acc_pkg::t_res             w_res;

    // Configuration registers
    assign o_cfg_ready = 1'b1;
    assign w_cfg_we    = i_cfg_valid && o_cfg_ready;
    assign w_shape_clr = w_cfg_we && ((i_cfg_index == bcsr_acc_pkg::CFG_BLOCK_ROWS)
                                   || (i_cfg_index == bcsr_acc_pkg::CFG_BLOCK_COLS));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_block_rows <= bcsr_acc_pkg::DIM_W'(1);
            r_block_cols <= bcsr_acc_pkg::DIM_W'(1);
            r_row_start  <= '0;
            r_row_end    <= bcsr_acc_pkg::ROW_END_RST;
        end else if (w_cfg_we) begin
            unique case (i_cfg_index)
                bcsr_acc_pkg::CFG_BLOCK_ROWS: r_block_rows <= i_cfg_data[bcsr_acc_pkg::DIM_W-1:0];
                bcsr_acc_pkg::CFG_BLOCK_COLS: r_block_cols <= i_cfg_data[bcsr_acc_pkg::DIM_W-1:0];
                bcsr_acc_pkg::CFG_ROW_START:  r_row_start  <= i_cfg_data;
                bcsr_acc_pkg::CFG_ROW_END:    r_row_end    <= i_cfg_data;
            endcase
        end
    end

    assign w_cfg.rows      = bcsr_acc_pkg::clamp_dim(r_block_rows);
    assign w_cfg.cols      = bcsr_acc_pkg::clamp_dim(r_block_cols);
    assign w_cfg.row_start = r_row_start;
    assign w_cfg.row_end   = r_row_end;

    // Accept a word whenever the command queue has room
    assign s_axis_tready = !w_q_full;
    assign w_accept      = s_axis_tvalid && s_axis_tready;

    bcsr_acc_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_shape_clr (w_shape_clr),
        .i_cfg       (w_cfg),
        .i_accept    (w_accept),
        .i_op        (bcsr_acc_pkg::t_op'(s_axis_tuser)),
        .i_index     (s_axis_tdata[11:0]),
        .i_value     (s_axis_tdata[43:12]),
        .i_block_row (s_axis_tdata[55:44]),
        .i_col_start (s_axis_tdata[67:56]),
        .o_cmd       (w_front_cmd)
    );

    bcsr_acc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_accept),
        .i_cmd   (w_front_cmd),
        .o_full  (w_q_full),
        .o_valid (w_q_valid),
        .o_cmd   (w_q_cmd),
        .i_pop   (w_q_pop)
    );

    bcsr_acc_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_shape_clr (w_shape_clr),
        .i_cmd_valid (w_q_valid),
        .i_cmd       (w_q_cmd),
        .o_pop       (w_q_pop),
        .o_res_valid (m_axis_tvalid),
        .o_res       (w_res),
        .i_res_ready (m_axis_tready)
    );

    assign m_axis_tdata = w_res.value;
    assign m_axis_tuser = w_res.sat;

endmodule

`default_nettype wire

FILE: design/bcsr_acc_ram.sv
// ----------------------------------------------------------------------------
// bcsr_acc_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module bcsr_acc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write, then read old contents on a same-address collision
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

FILE: design/bcsr_acc_front.sv
// ----------------------------------------------------------------------------
// bcsr_acc_front
// Front end: walks the block row/column counters and turns each accepted
// word into a command with resolved x and y addresses.
// ----------------------------------------------------------------------------
`default_nettype none

module bcsr_acc_front (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_shape_clr,
    input  wire bcsr_acc_pkg::t_cfg             i_cfg,
    input  wire logic                           i_accept,
    input  wire bcsr_acc_pkg::t_op              i_op,
    input  wire logic [bcsr_acc_pkg::IDX_W-1:0] i_index,
    input  wire logic [bcsr_acc_pkg::V_W-1:0]   i_value,
    input  wire logic [bcsr_acc_pkg::IDX_W-1:0] i_block_row,
    input  wire logic [bcsr_acc_pkg::IDX_W-1:0] i_col_start,
    output bcsr_acc_pkg::t_cmd                  o_cmd
);

    logic [bcsr_acc_pkg::CNT_W-1:0]  r_col, n_col;
    logic [bcsr_acc_pkg::CNT_W-1:0]  r_row, n_row;
    logic                            w_blk;
    logic                            w_last_col;
    logic                            w_last_row;
    logic [bcsr_acc_pkg::ROW_W-1:0]  w_col;
    logic [bcsr_acc_pkg::MROW_W-1:0] w_mrow;
    logic                            w_y_ok;

    assign w_blk = (i_op == bcsr_acc_pkg::OP_BLOCK);

    // Position of this element inside its block
    assign w_last_col = (({1'b0, r_col} + 1'b1) >= i_cfg.cols);
    assign w_last_row = (({1'b0, r_row} + 1'b1) >= i_cfg.rows);

    // x column and target matrix row
    assign w_col  = bcsr_acc_pkg::ROW_W'(i_col_start) + bcsr_acc_pkg::ROW_W'(r_col);
    assign w_mrow = bcsr_acc_pkg::MROW_W'(i_block_row) * bcsr_acc_pkg::MROW_W'(i_cfg.rows)
                  + bcsr_acc_pkg::MROW_W'(r_row);
    assign w_y_ok = (w_mrow >= bcsr_acc_pkg::MROW_W'(i_cfg.row_start))
                 && (w_mrow <  bcsr_acc_pkg::MROW_W'(i_cfg.row_end))
                 && (w_mrow <  bcsr_acc_pkg::MROW_W'(bcsr_acc_pkg::VEC_DEPTH));

    // Build the command
    always_comb begin
        o_cmd.op     = i_op;
        o_cmd.x_addr = w_blk ? w_col[bcsr_acc_pkg::VEC_AW-1:0] : i_index;
        o_cmd.x_ok   = (w_col < bcsr_acc_pkg::ROW_W'(bcsr_acc_pkg::VEC_DEPTH));
        o_cmd.y_addr = w_blk ? w_mrow[bcsr_acc_pkg::VEC_AW-1:0] : i_index;
        o_cmd.y_en   = w_blk ? (w_last_col && w_y_ok) : (i_op == bcsr_acc_pkg::OP_LOAD_Y);
        o_cmd.eor    = w_last_col;
        o_cmd.value  = i_value;
    end

    // Advance the counters on each block element; a block shape write clears them
    always_comb begin
        n_col = r_col;
        n_row = r_row;
        if (i_shape_clr) begin
            n_col = '0;
            n_row = '0;
        end else if (i_accept && w_blk) begin
            if (w_last_col) begin
                n_col = '0;
                n_row = w_last_row ? '0 : r_row + 1'b1;
            end else begin
                n_col = r_col + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

endmodule

`default_nettype wire

FILE: design/bcsr_acc_queue.sv
// ----------------------------------------------------------------------------
// bcsr_acc_queue
// Short command queue that decouples the front end from the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module bcsr_acc_queue (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_push,
    input  wire bcsr_acc_pkg::t_cmd i_cmd,
    output logic                    o_full,
    output logic                    o_valid,
    output bcsr_acc_pkg::t_cmd      o_cmd,
    input  wire logic               i_pop
);

    bcsr_acc_pkg::t_cmd            r_mem [bcsr_acc_pkg::Q_DEPTH];
    logic [bcsr_acc_pkg::Q_AW-1:0] r_wp, r_rp;
    logic [bcsr_acc_pkg::Q_AW:0]   r_cnt, n_cnt;

    assign o_full  = (r_cnt == (bcsr_acc_pkg::Q_AW+1)'(bcsr_acc_pkg::Q_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_cmd   = r_mem[r_rp];

    // Store pushed commands
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_cmd;
        end
    end

    // Track fill level
    always_comb begin
        n_cnt = r_cnt;
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (!i_push && i_pop) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            r_cnt <= n_cnt;
        end
    end

endmodule

`default_nettype wire

FILE: design/bcsr_acc_back.sv
// ----------------------------------------------------------------------------
// bcsr_acc_back
// Back end: x store read, multiply, row accumulation, y read-modify-write
// with forwarding, and the result queue toward the output channel.
// ----------------------------------------------------------------------------
`default_nettype none

module bcsr_acc_back (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_shape_clr,
    input  wire logic               i_cmd_valid,
    input  wire bcsr_acc_pkg::t_cmd i_cmd,
    output logic                    o_pop,
    output logic                    o_res_valid,
    output bcsr_acc_pkg::t_res      o_res,
    input  wire logic               i_res_ready
);

    localparam int YS_W = bcsr_acc_pkg::Y_W + 1;

    // Credits for result queue slots
    logic [bcsr_acc_pkg::OUT_AW:0]      r_credit;
    logic                               w_res_take;
    logic                               w_pop_rd;

    // Stage 1: x read data
    logic                               r_b1_vld;
    bcsr_acc_pkg::t_cmd                 r_b1;
    logic [bcsr_acc_pkg::V_W-1:0]       w_x_rdata;
    logic signed [bcsr_acc_pkg::V_W-1:0]    w_b1_val;
    logic signed [bcsr_acc_pkg::V_W-1:0]    w_xv;
    logic signed [bcsr_acc_pkg::PROD_W-1:0] w_prod;

    // Stage 2: row accumulation
    logic                               r_b2_vld;
    bcsr_acc_pkg::t_cmd                 r_b2;
    logic [bcsr_acc_pkg::PROD_W-1:0]    r_b2_prod;
    logic [bcsr_acc_pkg::Y_W-1:0]       w_term;
    logic [bcsr_acc_pkg::Y_W:0]         w_rs;
    logic                               w_b2_blk;
    logic [bcsr_acc_pkg::Y_W-1:0]       r_row_sum;
    logic                               r_row_sat;

    // Stage 3: y update
    logic                               r_b3_vld;
    bcsr_acc_pkg::t_op                  r_b3_op;
    logic [bcsr_acc_pkg::VEC_AW-1:0]    r_b3_yaddr;
    logic                               r_b3_yen;
    logic [bcsr_acc_pkg::Y_W-1:0]       r_b3_total;
    logic                               r_b3_tsat;
    logic [bcsr_acc_pkg::V_W-1:0]       r_b3_value;
    logic [YS_W-1:0]                    w_y_rdata;
    logic [YS_W-1:0]                    w_yold;
    logic [bcsr_acc_pkg::Y_W:0]         w_ysum;
    logic                               w_y_we;
    logic [YS_W-1:0]                    w_y_wdata;
    logic                               w_res_push;

    // Last y write, for read-after-write forwarding
    logic                               r_lw_vld;
    logic [bcsr_acc_pkg::VEC_AW-1:0]    r_lw_addr;
    logic [YS_W-1:0]                    r_lw_data;

    // Result queue
    bcsr_acc_pkg::t_res                 r_of_mem [bcsr_acc_pkg::OUT_DEPTH];
    logic [bcsr_acc_pkg::OUT_AW-1:0]    r_of_wp, r_of_rp;
    logic [bcsr_acc_pkg::OUT_AW:0]      r_of_cnt;

    // Take a read only when a result slot is reserved for it
    assign w_res_take = o_res_valid && i_res_ready;
    assign o_pop = i_cmd_valid
                && ((i_cmd.op != bcsr_acc_pkg::OP_READ_Y)
                    || (r_credit < (bcsr_acc_pkg::OUT_AW+1)'(bcsr_acc_pkg::OUT_DEPTH)));
    assign w_pop_rd = o_pop && (i_cmd.op == bcsr_acc_pkg::OP_READ_Y);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_credit <= '0;
        end else if (w_pop_rd && !w_res_take) begin
            r_credit <= r_credit + 1'b1;
        end else if (!w_pop_rd && w_res_take) begin
            r_credit <= r_credit - 1'b1;
        end
    end

    // x store: loads write, block elements read, both at pop
    bcsr_acc_ram #(
        .WIDTH (bcsr_acc_pkg::V_W),
        .DEPTH (bcsr_acc_pkg::VEC_DEPTH)
    ) u_x_ram (
        .i_clk   (i_clk),
        .i_we    (o_pop && (i_cmd.op == bcsr_acc_pkg::OP_LOAD_X)),
        .i_waddr (i_cmd.x_addr),
        .i_wdata (i_cmd.value),
        .i_raddr (i_cmd.x_addr),
        .o_rdata (w_x_rdata)
    );

    // Stage valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b1_vld <= 1'b0;
            r_b2_vld <= 1'b0;
            r_b3_vld <= 1'b0;
            r_lw_vld <= 1'b0;
        end else begin
            r_b1_vld <= o_pop;
            r_b2_vld <= r_b1_vld;
            r_b3_vld <= r_b2_vld;
            r_lw_vld <= w_y_we;
        end
    end

    // Multiply element by x; a column past the store reads as zero
    assign w_b1_val = $signed(r_b1.value);
    assign w_xv     = r_b1.x_ok ? $signed(w_x_rdata) : '0;
    assign w_prod   = w_b1_val * w_xv;

    always_ff @(posedge i_clk) begin
        r_b1      <= i_cmd;
        r_b2      <= r_b1;
        r_b2_prod <= w_prod;
    end

    // Accumulate Q32.16 product into the row sum
    assign w_term   = r_b2_prod[bcsr_acc_pkg::FRAC_W +: bcsr_acc_pkg::Y_W];
    assign w_rs     = bcsr_acc_pkg::sat_add(r_row_sum, w_term);
    assign w_b2_blk = r_b2_vld && (r_b2.op == bcsr_acc_pkg::OP_BLOCK);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_shape_clr) begin
            r_row_sum <= '0;
            r_row_sat <= 1'b0;
        end else if (w_b2_blk) begin
            if (r_b2.eor) begin
                r_row_sum <= '0;
                r_row_sat <= 1'b0;
            end else begin
                r_row_sum <= w_rs[bcsr_acc_pkg::Y_W-1:0];
                r_row_sat <= r_row_sat | w_rs[bcsr_acc_pkg::Y_W];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_b3_op    <= r_b2.op;
        r_b3_yaddr <= r_b2.y_addr;
        r_b3_yen   <= r_b2.y_en;
        r_b3_total <= w_rs[bcsr_acc_pkg::Y_W-1:0];
        r_b3_tsat  <= r_row_sat | w_rs[bcsr_acc_pkg::Y_W];
        r_b3_value <= r_b2.value;
    end

    // y store with its saturation flag in the top bit
    bcsr_acc_ram #(
        .WIDTH (YS_W),
        .DEPTH (bcsr_acc_pkg::VEC_DEPTH)
    ) u_y_ram (
        .i_clk   (i_clk),
        .i_we    (w_y_we),
        .i_waddr (r_b3_yaddr),
        .i_wdata (w_y_wdata),
        .i_raddr (r_b2.y_addr),
        .o_rdata (w_y_rdata)
    );

    // Forward the previous write when it hit the same entry
    assign w_yold = (r_lw_vld && (r_lw_addr == r_b3_yaddr)) ? r_lw_data : w_y_rdata;
    assign w_ysum = bcsr_acc_pkg::sat_add(w_yold[bcsr_acc_pkg::Y_W-1:0], r_b3_total);
    assign w_y_we = r_b3_vld && r_b3_yen;

    always_comb begin
        if (r_b3_op == bcsr_acc_pkg::OP_LOAD_Y) begin
            w_y_wdata = {1'b0, {(bcsr_acc_pkg::Y_W - bcsr_acc_pkg::V_W)
                                {r_b3_value[bcsr_acc_pkg::V_W-1]}}, r_b3_value};
        end else begin
            w_y_wdata = {w_yold[bcsr_acc_pkg::Y_W] | r_b3_tsat | w_ysum[bcsr_acc_pkg::Y_W],
                         w_ysum[bcsr_acc_pkg::Y_W-1:0]};
        end
    end

    always_ff @(posedge i_clk) begin
        r_lw_addr <= r_b3_yaddr;
        r_lw_data <= w_y_wdata;
    end

    // Result queue toward the output channel
    assign w_res_push  = r_b3_vld && (r_b3_op == bcsr_acc_pkg::OP_READ_Y);
    assign o_res_valid = (r_of_cnt != '0);
    assign o_res       = r_of_mem[r_of_rp];

    always_ff @(posedge i_clk) begin
        if (w_res_push) begin
            r_of_mem[r_of_wp] <= '{sat: w_yold[bcsr_acc_pkg::Y_W],
                                   value: w_yold[bcsr_acc_pkg::Y_W-1:0]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_of_wp  <= '0;
            r_of_rp  <= '0;
            r_of_cnt <= '0;
        end else begin
            if (w_res_push) begin
                r_of_wp <= r_of_wp + 1'b1;
            end
            if (w_res_take) begin
                r_of_rp <= r_of_rp + 1'b1;
            end
            if (w_res_push && !w_res_take) begin
                r_of_cnt <= r_of_cnt + 1'b1;
            end else if (!w_res_push && w_res_take) begin
                r_of_cnt <= r_of_cnt - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire
